### hdl/ubh_pkg.sv
// ----------------------------------------------------------------------------
// ubh_pkg
// shared command codes, payload types and register map for the histogram
// ----------------------------------------------------------------------------
package ubh_pkg;

	localparam logic [1:0] CMD_ADD   = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;
	localparam logic [1:0] CMD_NOP   = 2'd3;

	localparam logic [1:0] REG_LOW_BOUND  = 2'd0;
	localparam logic [1:0] REG_BIN_STEP   = 2'd1;
	localparam logic [1:0] REG_CELL_COUNT = 2'd2;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [31:0] sample_value;
		logic [7:0]  bin_index;
	} ubh_in_t;

	typedef struct packed {
		logic        in_range;
		logic [31:0] bin_count;
		logic [16:0] fraction_of_peak;
		logic [31:0] cell_low_edge;
		logic [31:0] total_samples;
		logic [31:0] missed_samples;
		logic [8:0]  covered_cells;
		logic [31:0] peak_count;
	} ubh_out_t;

endpackage

### hdl/ubh_in_if.sv
// ----------------------------------------------------------------------------
// ubh_in_if / ubh_out_if
// valid/ready channels carrying command beats and result beats
// ----------------------------------------------------------------------------
interface ubh_in_if import ubh_pkg::*; ();
	logic    valid;
	logic    ready;
	ubh_in_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface ubh_out_if import ubh_pkg::*; ();
	logic     valid;
	logic     ready;
	ubh_out_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### hdl/ubh_divider.sv
// ----------------------------------------------------------------------------
// ubh_divider
// radix-2 restoring divider, one quotient bit a cycle
// ----------------------------------------------------------------------------
module ubh_divider import ubh_pkg::*; #(
	parameter int NUM_BITS = 33,
	parameter int DEN_BITS = 32,
	parameter int Q_BITS   = 33
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [NUM_BITS-1:0] num,
	input  logic [DEN_BITS-1:0] den,
	output logic                busy,
	output logic                done,
	output logic [Q_BITS-1:0]   quo
);
	localparam int CW = $clog2(NUM_BITS + 1);
	localparam int RW = DEN_BITS + 1;

	logic [CW-1:0]       cnt_q;
	logic [NUM_BITS-1:0] n_q;
	logic [RW-1:0]       r_q;
	logic [DEN_BITS-1:0] d_q;
	logic [Q_BITS-1:0]   q_q;
	logic [RW-1:0]       r_sh;
	logic                ge;

	assign r_sh = {r_q[RW-2:0], n_q[NUM_BITS-1]};
	assign ge   = r_sh >= {1'b0, d_q};
	assign quo  = q_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy  <= 1'b0;
			done  <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy  <= 1'b1;
				cnt_q <= CW'(NUM_BITS);
			end else if (busy) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= num;
			d_q <= den;
			r_q <= '0;
			q_q <= '0;
		end else if (busy) begin
			n_q <= n_q << 1;
			r_q <= ge ? r_sh - {1'b0, d_q} : r_sh;
			q_q <= {q_q[Q_BITS-2:0], ge};
		end
	end
endmodule

### hdl/ubh_regs.sv
// ----------------------------------------------------------------------------
// ubh_regs
// apb register file for the bin geometry
// ----------------------------------------------------------------------------
module ubh_regs import ubh_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic [31:0] low_bound,
	output logic [31:0] bin_step,
	output logic [8:0]  cell_count
);
	logic [1:0] idx;
	assign idx    = paddr[3:2];
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_bound  <= '0;
			bin_step   <= 32'd65536;
			cell_count <= 9'd256;
		end else if (psel && penable && pwrite) begin
			unique case (idx)
				REG_LOW_BOUND:  low_bound  <= pwdata;
				REG_BIN_STEP:   bin_step   <= pwdata;
				REG_CELL_COUNT: cell_count <= pwdata[8:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_LOW_BOUND:  prdata = low_bound;
			REG_BIN_STEP:   prdata = bin_step;
			REG_CELL_COUNT: prdata = {23'd0, cell_count};
			default:        prdata = '0;
		endcase
	end
endmodule

### hdl/uniform_bin_histogram_unit.sv
// ----------------------------------------------------------------------------
// uniform_bin_histogram_unit
// uniform-bin histogram over signed q16.16 samples with a counter memory
//
//  channel  dir  handshake    payload
//  in       in   valid/ready  cmd, sample_value, bin_index
//  out      out  valid/ready  in_range .. peak_count
//  cfg      in   apb          low_bound, bin_step, cell_count
//
// one beat at a time: an add runs the bin divider (33 steps), then, unless
// the fraction is 0 or full, the fraction divider (49 steps); a missed add
// only the former, a read only the latter, a clear or no-op neither.
// the counter memory is read, updated and written back in one pass.
// reset clears valid bits at once, no clearing pass.
// the next beat is taken while a result waits in the output register.
// ----------------------------------------------------------------------------
module uniform_bin_histogram_unit import ubh_pkg::*; #(
	parameter int MAX_CELLS  = 256,
	parameter int COUNT_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	ubh_in_if.sink      in_ch,
	ubh_out_if.source   out_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	localparam int AW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
	localparam int CB = COUNT_BITS;
	localparam int FB = CB + 17;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_BDIV  = 4'd1;
	localparam logic [3:0] ST_MRD   = 4'd2;
	localparam logic [3:0] ST_UPD   = 4'd3;
	localparam logic [3:0] ST_FSTRT = 4'd4;
	localparam logic [3:0] ST_FDIV  = 4'd5;
	localparam logic [3:0] ST_DONE  = 4'd6;
	localparam logic [3:0] ST_EDGE  = 4'd7;

	logic [31:0] low_bound, bin_step;
	logic [8:0]  cell_count;

	ubh_regs u_regs (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.low_bound, .bin_step, .cell_count
	);

	logic [3:0]  st_q;
	ubh_in_t     cur_q;
	logic        hit_q;
	logic [AW-1:0] bin_q;
	logic [CB-1:0] cnt_q;
	logic [CB-1:0] tot_q, miss_q, peak_q;
	logic [8:0]    cov_q;
	logic [16:0]   frac_q;
	logic [31:0]   edge_q;
	logic [31:0]   mul_q;
	logic          ovalid_q;
	ubh_out_t      odata_q;

	logic [CB-1:0] mem [MAX_CELLS];
	logic [CB-1:0] rd_s1;
	logic [MAX_CELLS-1:0] valid_q;

	logic [CB-1:0] cmax;
	assign cmax = '1;

	function automatic logic [31:0] sat32(input logic [CB-1:0] v);
		logic [63:0] w;
		w = 64'(v);
		return (w > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : w[31:0];
	endfunction

	// bin divider on |diff|
	logic signed [32:0] diff;
	logic [32:0] mag;
	logic        bstart, bbusy, bdone;
	logic [32:0] bquo;
	assign diff = $signed({cur_q.sample_value[31], cur_q.sample_value})
	            - $signed({low_bound[31], low_bound});
	assign mag  = diff[32] ? 33'(-diff) : 33'(diff);

	ubh_divider #(.NUM_BITS(33), .DEN_BITS(32), .Q_BITS(33)) u_bdiv (
		.clk, .arst_n, .start(bstart), .num(mag), .den(bin_step),
		.busy(bbusy), .done(bdone), .quo(bquo)
	);

	// fraction divider: count*65536 / peak, low 17 quotient bits kept
	logic fstart, fbusy, fdone;
	logic [FB-1:0] fquo;
	ubh_divider #(.NUM_BITS(FB), .DEN_BITS(CB), .Q_BITS(FB)) u_fdiv (
		.clk, .arst_n, .start(fstart), .num({cnt_q, 17'd0} >> 1), .den(peak_q),
		.busy(fbusy), .done(fdone), .quo(fquo)
	);

	logic [9:0] ncells;
	assign ncells = (32'(cell_count) > MAX_CELLS) ? 10'(MAX_CELLS) : {1'b0, cell_count};

	logic miss_c;
	assign miss_c = (bin_step == 0) || (diff[32] && bquo != 0)
	             || (bquo >= 33'(ncells)) || (bquo >= 33'(MAX_CELLS));

	logic [CB-1:0] old_c, new_c;
	assign old_c = valid_q[bin_q] ? rd_s1 : '0;
	assign new_c = (old_c == cmax) ? old_c : old_c + 1'b1;

	assign in_ch.ready = (st_q == ST_IDLE);
	assign bstart = (st_q == ST_BDIV) && !bbusy && !bdone;
	assign fstart = (st_q == ST_FSTRT) && peak_q != 0 && cnt_q < peak_q && !fbusy;

	always_ff @(posedge clk) begin
		rd_s1 <= mem[bin_q];
		if (st_q == ST_UPD && cur_q.cmd == CMD_ADD)
			mem[bin_q] <= new_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_IDLE;
			ovalid_q <= 1'b0;
			valid_q  <= '0;
			tot_q    <= '0;
			miss_q   <= '0;
			peak_q   <= '0;
			cov_q    <= '0;
			cur_q    <= '0;
			hit_q    <= 1'b0;
			bin_q    <= '0;
			cnt_q    <= '0;
			frac_q   <= '0;
			edge_q   <= '0;
			mul_q    <= '0;
			odata_q  <= '0;
		end else begin
			if (out_ch.ready && st_q != ST_DONE) ovalid_q <= 1'b0;
			unique case (st_q)
				ST_IDLE: begin
					if (in_ch.valid && in_ch.ready) begin
						cur_q <= in_ch.data;
						hit_q <= 1'b0;
						cnt_q <= '0;
						frac_q <= '0;
						edge_q <= '0;
						unique case (in_ch.data.cmd)
							CMD_ADD: begin
								if (tot_q != cmax) tot_q <= tot_q + 1'b1;
								st_q <= ST_BDIV;
							end
							CMD_READ: begin
								bin_q <= AW'(in_ch.data.bin_index);
								hit_q <= 10'(in_ch.data.bin_index) < ncells;
								mul_q <= 32'(in_ch.data.bin_index) * bin_step;
								st_q  <= ST_MRD;
							end
							CMD_CLEAR: begin
								valid_q <= '0;
								tot_q <= '0; miss_q <= '0; peak_q <= '0; cov_q <= '0;
								st_q <= ST_DONE;
							end
							default: st_q <= ST_DONE;
						endcase
					end
				end
				ST_BDIV: begin
					if (bdone) begin
						if (miss_c) begin
							if (miss_q != cmax) miss_q <= miss_q + 1'b1;
							edge_q <= low_bound;
							st_q <= ST_DONE;
						end else begin
							hit_q <= 1'b1;
							bin_q <= AW'(bquo);
							mul_q <= 32'(bquo[8:0]) * bin_step;
							st_q  <= ST_MRD;
						end
					end
				end
				ST_MRD: st_q <= ST_UPD;
				ST_UPD: begin
					edge_q <= low_bound + mul_q;
					if (cur_q.cmd == CMD_ADD) begin
						valid_q[bin_q] <= 1'b1;
						cnt_q <= new_c;
						if (old_c == 0 && cov_q != 9'h1FF) cov_q <= cov_q + 1'b1;
						if (new_c > peak_q) peak_q <= new_c;
					end else begin
						cnt_q <= (32'(cur_q.bin_index) < MAX_CELLS) ? old_c : '0;
					end
					st_q <= ST_FSTRT;
				end
				ST_FSTRT: begin
					if (peak_q == 0) begin
						frac_q <= '0; st_q <= ST_DONE;
					end else if (cnt_q >= peak_q) begin
						frac_q <= 17'd65536; st_q <= ST_DONE;
					end else begin
						st_q <= ST_FDIV;
					end
				end
				ST_FDIV: begin
					if (fdone) begin
						frac_q <= fquo[16:0];
						st_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!ovalid_q || out_ch.ready) begin
						ovalid_q <= 1'b1;
						odata_q.in_range         <= hit_q;
						odata_q.bin_count        <= sat32(cnt_q);
						odata_q.fraction_of_peak <= frac_q;
						odata_q.cell_low_edge    <= edge_q;
						odata_q.total_samples    <= sat32(tot_q);
						odata_q.missed_samples   <= sat32(miss_q);
						odata_q.covered_cells    <= cov_q;
						odata_q.peak_count       <= sat32(peak_q);
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign out_ch.valid = ovalid_q;
	assign out_ch.data  = odata_q;
endmodule
